FILE: src/hhdc_pkg.sv
// Shared types, codes and fixed-point constants of the heading drive controller.
`default_nettype none
package hhdc_pkg;

  localparam int QUAT_W = 16;
  localparam int QACC_W = 34;
  localparam int Z_W = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam int STALE_W = 10;
  localparam int CORDIC_LAST = 15;

  localparam logic [1:0] OP_VELOCITY = 2'd0;
  localparam logic [1:0] OP_ODOMETRY = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_HEADING = 2'd0;
  localparam logic [1:0] KIND_DRIVE = 2'd1;
  localparam logic [1:0] KIND_NO_SETPOINT = 2'd2;
  localparam logic [1:0] KIND_NO_HEADING = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STALE_TICKS = 3'd4;

  localparam logic signed [Z_W-1:0] Z_PI_Q16 = 20'sd205887;
  localparam logic signed [Z_W-1:0] Z_PI_Q12 = 20'sd12868;
  localparam logic signed [Z_W-1:0] Z_ROUND = 20'sd8;
  localparam logic signed [16:0] W_PI = 17'sd12868;
  localparam logic signed [16:0] W_TWO_PI = 17'sd25736;

  typedef enum logic [3:0] {
    S_IDLE, S_QMUL, S_TMUL, S_CINIT, S_CORDIC, S_ANGLE,
    S_SQRT, S_ERR, S_PMUL, S_SLEW, S_OUT
  } state_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input logic [3:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0: v = 20'sd51472;
      4'd1: v = 20'sd30386;
      4'd2: v = 20'sd16055;
      4'd3: v = 20'sd8150;
      4'd4: v = 20'sd4091;
      4'd5: v = 20'sd2047;
      4'd6: v = 20'sd1024;
      4'd7: v = 20'sd512;
      4'd8: v = 20'sd256;
      4'd9: v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: src/holonomic_to_heading_drive_controller.sv
// Heading drive controller: CORDIC heading, square-root speed, PD turn rate with slew limit.
// A velocity transfer only stores the setpoint; an odometry transfer yields a heading report.
// A fresh control tick yields a drive command.
// A stale tick goes straight to its status output; a zero vector skips the CORDIC iterations.
// Odometry and ticks share the 16-step CORDIC; ticks also run the DATA_WIDTH-step square root.
// Synchronous reset restores register defaults and marks command and odometry as stale.
`default_nettype none
module holonomic_to_heading_drive_controller #(
  parameter int DATA_WIDTH = 16,
  parameter int AGE_WIDTH = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] op,
  input  logic signed [DATA_WIDTH-1:0] vel_x,
  input  logic signed [DATA_WIDTH-1:0] vel_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [DATA_WIDTH-1:0] yaw_rate_in,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] kind,
  output logic signed [DATA_WIDTH-1:0] angular_cmd,
  output logic [14:0] linear_cmd,
  output logic signed [14:0] heading_err,
  output logic signed [14:0] heading_goal,
  output logic signed [14:0] heading_now,
  input  logic cfg_write,
  input  logic [hhdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hhdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hhdc_pkg::*;

  localparam int MUL_W = (DATA_WIDTH > QUAT_W) ? DATA_WIDTH : QUAT_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int CW = (((DATA_WIDTH + 16) > QACC_W) ? (DATA_WIDTH + 16) : QACC_W) + 3;
  localparam int NW = 2 * DATA_WIDTH;
  localparam int CNT_W = $clog2(MUL_W);
  localparam int AGE_CMP_W = (AGE_WIDTH > STALE_W) ? AGE_WIDTH : STALE_W;
  localparam int DIFF_W = ((DATA_WIDTH + 1 > 16) ? (DATA_WIDTH + 1) : 16) + 1;
  localparam logic signed [ACC_W-1:0] CORR_MAX = ACC_W'((longint'(1) << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] CORR_MIN = -CORR_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] PD_ROUND = ACC_W'(2048);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(DATA_WIDTH - 1);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic is_tick;

  logic [14:0] gain_p, gain_d, speed_lim, step_lim;
  logic [STALE_W-1:0] stale_lim;

  logic signed [DATA_WIDTH-1:0] goal_vx, goal_vy, yaw_rate_now, prev_angular;
  logic signed [14:0] yaw_now;
  logic [AGE_WIDTH-1:0] command_age, odometry_age;

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [ACC_W-1:0] acc_a, acc_b;
  logic signed [CW-1:0] cx, cy;
  logic signed [Z_W-1:0] cz;
  logic [NW-1:0] sq_n, sq_res, sq_bit;
  logic signed [14:0] goal, err;
  logic [14:0] lin;

  logic accept;
  logic [AGE_WIDTH-1:0] command_age_next, odometry_age_next;
  logic cmd_stale, odo_stale;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] product;
  logic signed [ACC_W-1:0] prod_ext;

  logic signed [CW-1:0] cx0, cy0, cdx, cdy;
  logic signed [Z_W-1:0] zr;
  logic signed [14:0] angle;
  logic [NW:0] sq_trial;
  logic signed [16:0] wrap_v, wrap_t;
  logic signed [14:0] err_next;
  logic [14:0] lin_next;
  logic signed [ACC_W-1:0] pd_shift;
  logic signed [DATA_WIDTH-1:0] corr;
  logic signed [DIFF_W-1:0] diff, step_ext, delta;
  logic signed [DATA_WIDTH-1:0] prev_angular_next;

  assign accept = in_valid && !in_stall;

  always_comb begin
    command_age_next = (command_age == '1) ? command_age : command_age + 1'b1;
    odometry_age_next = (odometry_age == '1) ? odometry_age : odometry_age + 1'b1;
    cmd_stale = (command_age_next == '1) ||
                (AGE_CMP_W'(command_age_next) > AGE_CMP_W'(stale_lim));
    odo_stale = (odometry_age_next == '1) ||
                (AGE_CMP_W'(odometry_age_next) > AGE_CMP_W'(stale_lim));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_QMUL: begin
        case (cnt[1:0])
          2'd0: begin mul_a = MUL_W'(qw); mul_b = MUL_W'(qz); end
          2'd1: begin mul_a = MUL_W'(qx); mul_b = MUL_W'(qy); end
          2'd2: begin mul_a = MUL_W'(qy); mul_b = MUL_W'(qy); end
          default: begin mul_a = MUL_W'(qz); mul_b = MUL_W'(qz); end
        endcase
      end
      S_TMUL: begin
        mul_a = cnt[0] ? MUL_W'(goal_vy) : MUL_W'(goal_vx);
        mul_b = mul_a;
      end
      S_PMUL: begin
        if (cnt[0]) begin
          mul_a = MUL_W'({1'b0, gain_d});
          mul_b = MUL_W'(yaw_rate_now);
        end else begin
          mul_a = MUL_W'({1'b0, gain_p});
          mul_b = MUL_W'(err);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product = mul_a * mul_b;
    prod_ext = ACC_W'(product);
  end

  always_comb begin
    if (is_tick) begin
      cx0 = CW'(goal_vx) <<< 16;
      cy0 = CW'(goal_vy) <<< 16;
    end else begin
      cy0 = CW'($signed(acc_a[QACC_W-1:0])) <<< 1;
      cx0 = (CW'(1) <<< 28) - (CW'($signed(acc_b[QACC_W-1:0])) <<< 1);
    end
    cdx = cy >>> cnt;
    cdy = cx >>> cnt;
    zr = (cz + Z_ROUND) >>> 4;
    if (zr > Z_PI_Q12) begin
      angle = 15'(Z_PI_Q12);
    end else if (zr < -Z_PI_Q12) begin
      angle = 15'(-Z_PI_Q12);
    end else begin
      angle = 15'(zr);
    end
  end

  always_comb begin
    sq_trial = {1'b0, sq_res} + {1'b0, sq_bit};
    lin_next = (sq_res >= NW'(speed_lim)) ? speed_lim : sq_res[14:0];
    wrap_v = 17'(goal) - 17'(yaw_now) + W_PI;
    if (wrap_v < 0) begin
      wrap_t = wrap_v + W_TWO_PI;
    end else if (wrap_v >= W_TWO_PI) begin
      wrap_t = wrap_v - W_TWO_PI;
    end else begin
      wrap_t = wrap_v;
    end
    err_next = 15'(wrap_t - W_PI);
  end

  always_comb begin
    pd_shift = (acc_b + PD_ROUND) >>> 12;
    if (pd_shift > CORR_MAX) begin
      corr = DATA_WIDTH'(CORR_MAX);
    end else if (pd_shift < CORR_MIN) begin
      corr = DATA_WIDTH'(CORR_MIN);
    end else begin
      corr = DATA_WIDTH'(pd_shift);
    end
    diff = DIFF_W'(corr) - DIFF_W'(prev_angular);
    step_ext = DIFF_W'({1'b0, step_lim});
    if (diff > step_ext) begin
      delta = step_ext;
    end else if (diff < -step_ext) begin
      delta = -step_ext;
    end else begin
      delta = diff;
    end
    prev_angular_next = prev_angular + DATA_WIDTH'(delta);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_ODOMETRY: state_next = S_QMUL;
            OP_TICK: state_next = (cmd_stale || odo_stale) ? S_OUT : S_TMUL;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_QMUL: if (cnt == CNT_W'(3)) state_next = S_CINIT;
      S_TMUL: if (cnt == CNT_W'(1)) state_next = S_CINIT;
      S_CINIT: state_next = (cx0 == '0 && cy0 == '0) ? S_ANGLE : S_CORDIC;
      S_CORDIC: if (cnt == CNT_W'(CORDIC_LAST)) state_next = S_ANGLE;
      S_ANGLE: state_next = is_tick ? S_SQRT : S_OUT;
      S_SQRT: if (cnt == SQRT_LAST) state_next = S_ERR;
      S_ERR: state_next = S_PMUL;
      S_PMUL: if (cnt == CNT_W'(1)) state_next = S_SLEW;
      S_SLEW: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    out_valid = (state == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= 15'd4096;
      gain_d <= 15'd410;
      speed_lim <= 15'd2048;
      step_lim <= 15'd205;
      stale_lim <= 10'd20;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_P: gain_p <= cfg_data;
        REG_GAIN_D: gain_d <= cfg_data;
        REG_SPEED_LIMIT: speed_lim <= cfg_data;
        REG_STEP_LIMIT: step_lim <= cfg_data;
        REG_STALE_TICKS: stale_lim <= cfg_data[STALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_vx <= '0;
      goal_vy <= '0;
      yaw_now <= '0;
      yaw_rate_now <= '0;
      prev_angular <= '0;
      command_age <= '1;
      odometry_age <= '1;
      is_tick <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_tick <= (op == OP_TICK);
            case (op)
              OP_VELOCITY: begin
                goal_vx <= vel_x;
                goal_vy <= vel_y;
                command_age <= '0;
              end
              OP_ODOMETRY: begin
                yaw_rate_now <= yaw_rate_in;
                odometry_age <= '0;
              end
              OP_TICK: begin
                command_age <= command_age_next;
                odometry_age <= odometry_age_next;
              end
              default: ;
            endcase
          end
        end
        S_ANGLE: if (!is_tick) yaw_now <= angle;
        S_SLEW: prev_angular <= prev_angular_next;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qx <= quat_x;
        qy <= quat_y;
        qz <= quat_z;
        qw <= quat_w;
        kind <= cmd_stale ? KIND_NO_SETPOINT : KIND_NO_HEADING;
        angular_cmd <= '0;
        linear_cmd <= '0;
        heading_err <= '0;
        heading_goal <= '0;
        heading_now <= '0;
      end
      S_QMUL: begin
        if (cnt[1]) begin
          acc_b <= cnt[0] ? acc_b + prod_ext : prod_ext;
        end else begin
          acc_a <= cnt[0] ? acc_a + prod_ext : prod_ext;
        end
      end
      S_TMUL: acc_a <= cnt[0] ? acc_a + prod_ext : prod_ext;
      S_CINIT: begin
        if (cx0 < 0) begin
          cx <= -cx0;
          cy <= -cy0;
          cz <= (cy0 >= 0) ? Z_PI_Q16 : -Z_PI_Q16;
        end else begin
          cx <= cx0;
          cy <= cy0;
          cz <= '0;
        end
      end
      S_CORDIC: begin
        if (cy > 0) begin
          cx <= cx + cdx;
          cy <= cy - cdy;
          cz <= cz + atan_entry(cnt[3:0]);
        end else begin
          cx <= cx - cdx;
          cy <= cy + cdy;
          cz <= cz - atan_entry(cnt[3:0]);
        end
      end
      S_ANGLE: begin
        if (is_tick) begin
          goal <= angle;
          sq_n <= acc_a[NW-1:0];
          sq_res <= '0;
          sq_bit <= NW'(1) << (NW - 2);
        end else begin
          kind <= KIND_HEADING;
          heading_now <= angle;
        end
      end
      S_SQRT: begin
        if ({1'b0, sq_n} >= sq_trial) begin
          sq_n <= sq_n - sq_trial[NW-1:0];
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_ERR: begin
        err <= err_next;
        lin <= lin_next;
      end
      S_PMUL: acc_b <= cnt[0] ? acc_b - prod_ext : prod_ext;
      S_SLEW: begin
        kind <= KIND_DRIVE;
        angular_cmd <= prev_angular_next;
        linear_cmd <= lin;
        heading_err <= err;
        heading_goal <= goal;
        heading_now <= '0;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while a result is pending");
  a_report_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HEADING |-> angular_cmd == '0 && linear_cmd == '0)
    else $error("heading report carries drive fields");
  a_speed_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DRIVE |-> linear_cmd <= speed_lim)
    else $error("speed command above limit");
  a_idle_after_transfer: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid) else $error("result repeated");
`endif

endmodule
`default_nettype wire
